// ===== rtl/core/itp_pkg.sv =====
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, codes and count/output evaluation for the interval timer.
// ----------------------------------------------------------------------------
package itp_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2
  } opcode_e;

  localparam logic [2:0] PORT_CTRL = 3'd3;
  localparam logic [2:0] PORT_GATE = 3'd4;
  localparam int unsigned GATE_CHAN = 2;

  // byte sequencing steps
  localparam logic [2:0] STEP_LSB     = 3'd1;
  localparam logic [2:0] STEP_MSB     = 3'd2;
  localparam logic [2:0] STEP_WORD_LO = 3'd3;
  localparam logic [2:0] STEP_WORD_HI = 3'd4;

  // latched count states
  localparam logic [1:0] HOLD_NONE = 2'd0;
  localparam logic [1:0] HOLD_LSB  = 2'd1;
  localparam logic [1:0] HOLD_MSB  = 2'd2;
  localparam logic [1:0] HOLD_WORD = 2'd3;

  localparam logic [1:0] SC_READBACK = 2'd3;
  localparam logic [16:0] FULL_COUNT = 17'h10000;

  typedef struct packed {
    logic       rd;
    logic       wr;
    logic       tick;
    logic [2:0] port;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [7:0] rd_data;
    logic       fault;
    logic       out_now;
    logic       out_next;
    logic       gate;
  } rsp_t;

  typedef struct packed {
    logic [16:0] count;
    logic        out;
  } eval_t;

  // Remaining count and output level from a channel's state.
  function automatic eval_t chan_eval(logic [2:0] mode, logic [16:0] n,
                                      logic [15:0] p, logic [16:0] g);
    eval_t       r;
    logic [2:0]  m;
    logic [16:0] t;
    logic [16:0] h;
    m = (mode >= 3'd6) ? mode - 3'd4 : mode;
    t = {p, 1'b0};
    if (t >= n) t = t - n;
    h = (n + 17'd1) >> 1;
    r.count = '0;
    r.out   = 1'b0;
    if (n != '0) begin
      case (m)
        3'd2: begin
          r.count = n - {1'b0, p};
          r.out   = (p == '0) && (g != '0);
        end
        3'd3: begin
          if (!n[0]) r.count = n - t;
          else if ({1'b0, p} < h) r.count = h - {1'b0, p};
          else r.count = {1'b0, p} - h;
          r.out = {1'b0, p} < h;
        end
        default: begin
          r.count = (n > g) ? n - g : '0;
          case (m)
            3'd0:    r.out = g >= n;
            3'd1:    r.out = g < n;
            default: r.out = g == n;
          endcase
        end
      endcase
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/itp_chan.sv =====
// ----------------------------------------------------------------------------
// itp_chan
// One counter channel: mode, byte sequencing, latches, ticking and gate.
// ----------------------------------------------------------------------------
module itp_chan #(
  parameter int unsigned CH_IDX = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  itp_pkg::cmd_t cmd_i,
  output itp_pkg::rsp_t rsp_o
);

  logic [16:0] init_q, init_d;
  logic [15:0] phase_q, phase_d;
  logic [16:0] prog_q, prog_d;
  logic [2:0]  mode_q, mode_d;
  logic [1:0]  bo_q, bo_d;
  logic [2:0]  rs_q, rs_d;
  logic [2:0]  ws_q, ws_d;
  logic [7:0]  low_q, low_d;
  logic [16:0] held_q, held_d;
  logic [1:0]  hs_q, hs_d;
  logic [7:0]  stat_q, stat_d;
  logic        sh_q, sh_d;
  logic        gate_q, gate_d;

  itp_pkg::eval_t cur, nxt;
  logic        own;
  logic        ctrl;
  logic [7:0]  rd;
  logic        flt;
  logic [15:0] ld_val;
  logic        ld;
  logic        do_latch;
  logic [2:0]  eff;
  logic [16:0] ph_inc;

  assign cur = itp_pkg::chan_eval(mode_q, init_q, phase_q, prog_q);
  assign nxt = itp_pkg::chan_eval(mode_d, init_d, phase_d, prog_d);
  assign own  = (cmd_i.port == 3'(CH_IDX));
  assign ctrl = cmd_i.wr && (cmd_i.port == itp_pkg::PORT_CTRL) && !cmd_i.data[0];
  assign eff  = (mode_q >= 3'd6) ? mode_q - 3'd4 : mode_q;
  assign ph_inc = {1'b0, phase_q} + 17'd1;

  always_comb begin
    init_d = init_q; phase_d = phase_q; prog_d = prog_q; mode_d = mode_q;
    bo_d = bo_q; rs_d = rs_q; ws_d = ws_q; low_d = low_q; held_d = held_q;
    hs_d = hs_q; stat_d = stat_q; sh_d = sh_q; gate_d = gate_q;
    rd = '0; flt = 1'b0; ld = 1'b0; ld_val = '0; do_latch = 1'b0;

    // channel port write
    if (cmd_i.wr && own) begin
      case (ws_q)
        itp_pkg::STEP_LSB: begin ld = 1'b1; ld_val = {8'h00, cmd_i.data}; end
        itp_pkg::STEP_MSB: begin ld = 1'b1; ld_val = {cmd_i.data, 8'h00}; end
        itp_pkg::STEP_WORD_LO: begin
          low_d = cmd_i.data;
          ws_d  = itp_pkg::STEP_WORD_HI;
        end
        itp_pkg::STEP_WORD_HI: begin
          ld = 1'b1; ld_val = {cmd_i.data, low_q};
          ws_d = itp_pkg::STEP_WORD_LO;
        end
        default: flt = 1'b1;
      endcase
    end
    if (ld) begin
      init_d  = (ld_val == '0) ? itp_pkg::FULL_COUNT : {1'b0, ld_val};
      phase_d = '0;
      prog_d  = '0;
    end

    // channel port read
    if (cmd_i.rd && own) begin
      if (sh_q) begin
        sh_d = 1'b0;
        rd   = stat_q;
      end else begin
        case (hs_q)
          itp_pkg::HOLD_LSB:  begin hs_d = itp_pkg::HOLD_NONE; rd = held_q[7:0]; end
          itp_pkg::HOLD_MSB:  begin hs_d = itp_pkg::HOLD_NONE; rd = held_q[15:8]; end
          itp_pkg::HOLD_WORD: begin hs_d = itp_pkg::HOLD_MSB;  rd = held_q[7:0]; end
          default: begin
            case (rs_q)
              itp_pkg::STEP_LSB: rd = cur.count[7:0];
              itp_pkg::STEP_MSB: rd = cur.count[15:8];
              itp_pkg::STEP_WORD_LO: begin
                rs_d = itp_pkg::STEP_WORD_HI; rd = cur.count[7:0];
              end
              itp_pkg::STEP_WORD_HI: begin
                rs_d = itp_pkg::STEP_WORD_LO; rd = cur.count[15:8];
              end
              default: flt = 1'b1;
            endcase
          end
        endcase
      end
    end

    // control word
    if (ctrl) begin
      if (cmd_i.data[7:6] == itp_pkg::SC_READBACK) begin
        if (cmd_i.data[1 + CH_IDX]) begin
          do_latch = !cmd_i.data[5];
          if (!cmd_i.data[4] && !sh_q) begin
            stat_d = {cur.out, 1'b0, bo_q, mode_q, 1'b0};
            sh_d   = 1'b1;
          end
        end
      end else if (cmd_i.data[7:6] == 2'(CH_IDX)) begin
        if (cmd_i.data[5:4] == 2'd0) begin
          do_latch = 1'b1;
        end else begin
          bo_d   = cmd_i.data[5:4];
          rs_d   = {1'b0, cmd_i.data[5:4]};
          ws_d   = {1'b0, cmd_i.data[5:4]};
          mode_d = cmd_i.data[3:1];
        end
      end
    end
    if (do_latch && (hs_q == itp_pkg::HOLD_NONE)) begin
      held_d = cur.count;
      hs_d   = bo_q;
    end

    // tick
    if (cmd_i.tick && (init_q != '0)) begin
      if (prog_q < init_q + 17'd1) prog_d = prog_q + 17'd1;
      phase_d = (ph_inc == init_q) ? '0 : ph_inc[15:0];
    end

    // gate, rising edge restarts in the retriggerable modes
    if (CH_IDX == itp_pkg::GATE_CHAN && cmd_i.wr && cmd_i.port == itp_pkg::PORT_GATE) begin
      if (eff != 3'd0 && eff != 3'd4 && !gate_q && cmd_i.data[0]) begin
        phase_d = '0;
        prog_d  = '0;
      end
      gate_d = cmd_i.data[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= '0; phase_q <= '0; prog_q <= '0; mode_q <= '0; bo_q <= '0;
      rs_q <= '0; ws_q <= '0; low_q <= '0; held_q <= '0; hs_q <= '0;
      stat_q <= '0; sh_q <= 1'b0; gate_q <= 1'b0;
    end else begin
      init_q <= init_d; phase_q <= phase_d; prog_q <= prog_d; mode_q <= mode_d;
      bo_q <= bo_d; rs_q <= rs_d; ws_q <= ws_d; low_q <= low_d; held_q <= held_d;
      hs_q <= hs_d; stat_q <= stat_d; sh_q <= sh_d; gate_q <= gate_d;
    end
  end

  assign rsp_o.rd_data  = rd;
  assign rsp_o.fault    = flt;
  assign rsp_o.out_now  = cur.out;
  assign rsp_o.out_next = nxt.out;
  assign rsp_o.gate     = gate_q;

endmodule

// ===== rtl/core/interval_timer_8254.sv =====
// ----------------------------------------------------------------------------
// interval_timer_8254
// Multi-channel 8254-style interval timer behind byte-wide ports.
// ----------------------------------------------------------------------------
// Each transfer is a port read, a port write or one timer tick. The block
// takes one transfer per clock cycle while ready and returns its result in
// the next cycle from an output register; the channel state updates in the
// same cycle the transfer is accepted, so back-to-back transfers see each
// other's effects. Ready drops only while a result sits unclaimed in the
// output register. Port 3 carries control words (mode, byte order, count
// latch, read-back), port 4 drives the gate of channel 2, ports 0..CHANNELS-1
// load and read counts. A zero load means 65536. BCD control words, accesses
// to a channel with no byte order, and control-port reads raise fault.
module interval_timer_8254 #(
  parameter int unsigned CHANNELS = 3
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  input  logic [2:0] port_select_i,
  input  logic [7:0] write_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_data_o,
  output logic       timer_out0_o,
  output logic       fault_o
);

  logic          acc;
  itp_pkg::cmd_t cmd;
  itp_pkg::rsp_t rsp [CHANNELS];
  logic [7:0]    rd_d, rd_q;
  logic          flt_d, flt_q;
  logic          out0_q;
  logic          vld_q;
  logic [7:0]    gate_rd;

  // accept whenever the result register is free or being drained
  assign in_ready_o = !vld_q || out_ready_i;
  assign acc        = in_valid_i && in_ready_o;

  assign cmd.rd   = acc && (opcode_i == itp_pkg::OP_READ);
  assign cmd.wr   = acc && (opcode_i == itp_pkg::OP_WRITE);
  assign cmd.tick = acc && (opcode_i == itp_pkg::OP_TICK);
  assign cmd.port = port_select_i;
  assign cmd.data = write_data_i;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    itp_chan #(.CH_IDX(c)) u_chan (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .cmd_i (cmd),
      .rsp_o (rsp[c])
    );
  end

  // gate port read: channel 2 out in bit 5, its gate in bit 0
  if (CHANNELS > itp_pkg::GATE_CHAN) begin : g_gate
    assign gate_rd = {2'b00, rsp[itp_pkg::GATE_CHAN].out_now, 4'h0,
                      rsp[itp_pkg::GATE_CHAN].gate};
  end else begin : g_nogate
    assign gate_rd = '0;
  end

  // merge channel responses; only the addressed channel drives nonzero
  always_comb begin
    rd_d  = '0;
    flt_d = 1'b0;
    for (int c = 0; c < CHANNELS; c++) begin
      rd_d  = rd_d | rsp[c].rd_data;
      flt_d = flt_d | rsp[c].fault;
    end
    if (cmd.rd && port_select_i == itp_pkg::PORT_CTRL) flt_d = 1'b1;
    if (cmd.wr && port_select_i == itp_pkg::PORT_CTRL && write_data_i[0]) flt_d = 1'b1;
    if (cmd.rd && port_select_i == itp_pkg::PORT_GATE) rd_d = gate_rd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (acc) begin
      vld_q <= 1'b1;
    end else if (out_ready_i) begin
      vld_q <= 1'b0;
    end
  end

  // hold the result until the consumer takes it
  always_ff @(posedge clk_i) begin
    if (acc) begin
      rd_q   <= rd_d;
      flt_q  <= flt_d;
      out0_q <= rsp[0].out_next;
    end
  end

  assign out_valid_o  = vld_q;
  assign read_data_o  = rd_q;
  assign fault_o      = flt_q;
  assign timer_out0_o = out0_q;

endmodule

// ===== tb/tb_interval_timer_8254_checker.sv =====
// ----------------------------------------------------------------------------
// tb_interval_timer_8254_checker
// Watches all three channels of the interval timer, predicts every result and
// compares it field by field; hands the number of mismatches to the top.
// ----------------------------------------------------------------------------
module tb_interval_timer_8254_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [1:0] opcode_i,
  input  logic [2:0] port_select_i,
  input  logic [7:0] write_data_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] read_data_i,
  input  logic       timer_out0_i,
  input  logic       fault_i,
  output int         errors_o,
  output int         pending_o
);

  localparam int NCH = 3;

  typedef struct packed {
    logic [7:0] rdata;
    logic       tout;
    logic       flt;
  } timer_rsp_t;

  logic [16:0] load_val   [NCH];
  logic [15:0] tick_phase [NCH];
  logic [16:0] tick_prog  [NCH];
  logic [2:0]  mode_bits  [NCH];
  logic [1:0]  rw_order   [NCH];
  logic [2:0]  rd_seq     [NCH];
  logic [2:0]  wr_seq     [NCH];
  logic [7:0]  lo_byte    [NCH];
  logic [16:0] snap_count [NCH];
  logic [1:0]  snap_state [NCH];
  logic [7:0]  stat_byte  [NCH];
  logic        stat_valid [NCH];
  logic        gate_q;

  timer_rsp_t expected_rsp_q[$];
  int         mismatches;

  assign errors_o  = mismatches;
  assign pending_o = expected_rsp_q.size();

  function automatic logic [2:0] active_mode(int c);
    return (mode_bits[c] >= 3'd6) ? mode_bits[c] - 3'd4 : mode_bits[c];
  endfunction

  function automatic logic [16:0] count_left(int c);
    logic [16:0] n;
    logic [16:0] p;
    logic [16:0] h;
    n = load_val[c];
    p = {1'b0, tick_phase[c]};
    h = (n + 17'd1) >> 1;
    if (n == '0) return '0;
    case (active_mode(c))
      3'd2: return n - p;
      3'd3: begin
        if (!n[0]) return n - ((2 * p) % n);
        return (p < h) ? h - p : p - h;
      end
      default: return (n > tick_prog[c]) ? {1'b0, 16'(n - tick_prog[c])} : '0;
    endcase
  endfunction

  function automatic logic out_of(int c);
    logic [16:0] n;
    n = load_val[c];
    if (n == '0) return 1'b0;
    case (active_mode(c))
      3'd0: return tick_prog[c] >= n;
      3'd1: return tick_prog[c] < n;
      3'd2: return tick_phase[c] == '0 && tick_prog[c] != '0;
      3'd3: return {1'b0, tick_phase[c]} < ((n + 17'd1) >> 1);
      default: return tick_prog[c] == n;
    endcase
  endfunction

  function automatic void load_count(int c, logic [15:0] v);
    load_val[c]   = (v == '0) ? itp_pkg::FULL_COUNT : {1'b0, v};
    tick_phase[c] = '0;
    tick_prog[c]  = '0;
  endfunction

  function automatic void snap(int c);
    if (snap_state[c] == itp_pkg::HOLD_NONE) begin
      snap_count[c] = count_left(c);
      snap_state[c] = rw_order[c];
    end
  endfunction

  // Advance the timer model by one transfer and return its result.
  function automatic timer_rsp_t timer_step(logic [1:0] op, logic [2:0] port,
                                            logic [7:0] d);
    timer_rsp_t  r;
    logic [16:0] v;
    int          c;
    r = '0;
    c = port;
    if (op == itp_pkg::OP_READ) begin
      if (port < NCH) begin
        if (stat_valid[c]) begin
          stat_valid[c] = 1'b0;
          r.rdata = stat_byte[c];
        end else if (snap_state[c] == itp_pkg::HOLD_LSB) begin
          snap_state[c] = itp_pkg::HOLD_NONE;
          r.rdata = snap_count[c][7:0];
        end else if (snap_state[c] == itp_pkg::HOLD_MSB) begin
          snap_state[c] = itp_pkg::HOLD_NONE;
          r.rdata = snap_count[c][15:8];
        end else if (snap_state[c] == itp_pkg::HOLD_WORD) begin
          snap_state[c] = itp_pkg::HOLD_MSB;
          r.rdata = snap_count[c][7:0];
        end else begin
          v = count_left(c);
          case (rd_seq[c])
            itp_pkg::STEP_LSB: r.rdata = v[7:0];
            itp_pkg::STEP_MSB: r.rdata = v[15:8];
            itp_pkg::STEP_WORD_LO: begin
              rd_seq[c] = itp_pkg::STEP_WORD_HI; r.rdata = v[7:0];
            end
            itp_pkg::STEP_WORD_HI: begin
              rd_seq[c] = itp_pkg::STEP_WORD_LO; r.rdata = v[15:8];
            end
            default: r.flt = 1'b1;
          endcase
        end
      end else if (port == itp_pkg::PORT_CTRL) begin
        r.flt = 1'b1;
      end else if (port == itp_pkg::PORT_GATE) begin
        r.rdata = {2'b0, out_of(itp_pkg::GATE_CHAN), 4'b0, gate_q};
      end
    end else if (op == itp_pkg::OP_WRITE) begin
      if (port < NCH) begin
        case (wr_seq[c])
          itp_pkg::STEP_LSB: load_count(c, {8'h00, d});
          itp_pkg::STEP_MSB: load_count(c, {d, 8'h00});
          itp_pkg::STEP_WORD_LO: begin
            lo_byte[c] = d; wr_seq[c] = itp_pkg::STEP_WORD_HI;
          end
          itp_pkg::STEP_WORD_HI: begin
            load_count(c, {d, lo_byte[c]}); wr_seq[c] = itp_pkg::STEP_WORD_LO;
          end
          default: r.flt = 1'b1;
        endcase
      end else if (port == itp_pkg::PORT_CTRL) begin
        if (d[0]) begin
          r.flt = 1'b1;
        end else if (d[7:6] == itp_pkg::SC_READBACK) begin
          for (int k = 0; k < NCH; k++) begin
            if (d[k+1]) begin
              if (!d[5]) snap(k);
              if (!d[4] && !stat_valid[k]) begin
                stat_byte[k]  = {out_of(k), 1'b0, rw_order[k], mode_bits[k], 1'b0};
                stat_valid[k] = 1'b1;
              end
            end
          end
        end else if (d[7:6] < NCH) begin
          c = d[7:6];
          if (d[5:4] == 2'd0) snap(c);
          else begin
            rw_order[c]  = d[5:4];
            rd_seq[c]    = {1'b0, d[5:4]};
            wr_seq[c]    = {1'b0, d[5:4]};
            mode_bits[c] = d[3:1];
          end
        end
      end else if (port == itp_pkg::PORT_GATE) begin
        if (active_mode(itp_pkg::GATE_CHAN) != 3'd0 &&
            active_mode(itp_pkg::GATE_CHAN) != 3'd4 && !gate_q && d[0]) begin
          tick_phase[itp_pkg::GATE_CHAN] = '0;
          tick_prog[itp_pkg::GATE_CHAN]  = '0;
        end
        gate_q = d[0];
      end
    end else if (op == itp_pkg::OP_TICK) begin
      for (int k = 0; k < NCH; k++) begin
        if (load_val[k] != '0) begin
          if (tick_prog[k] < load_val[k] + 17'd1) tick_prog[k]++;
          tick_phase[k] = 16'((17'(tick_phase[k]) + 17'd1) % load_val[k]);
        end
      end
    end
    r.tout = out_of(0);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch: %s got %0h expected %0h", what, got, want);
    mismatches++;
  endtask

  initial begin
    mismatches = 0;
    gate_q = 1'b0;
    for (int k = 0; k < NCH; k++) begin
      load_val[k] = '0; tick_phase[k] = '0; tick_prog[k] = '0;
      mode_bits[k] = '0; rw_order[k] = '0; rd_seq[k] = '0; wr_seq[k] = '0;
      lo_byte[k] = '0; snap_count[k] = '0; snap_state[k] = '0;
      stat_byte[k] = '0; stat_valid[k] = 1'b0;
    end
  end

  always @(posedge clk_i) begin
    timer_rsp_t want;
    if (rst_ni) begin
      // Check the result first: its expectation was queued by an earlier transfer.
      if (out_valid_i && out_ready_i) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("unexpected result", read_data_i, 0);
        end else begin
          want = expected_rsp_q.pop_front();
          if (read_data_i !== want.rdata) report_mismatch("read_data", read_data_i, want.rdata);
          if (timer_out0_i !== want.tout) report_mismatch("timer_out0", timer_out0_i, want.tout);
          if (fault_i !== want.flt) report_mismatch("fault", fault_i, want.flt);
        end
      end
      if (in_valid_i && in_ready_i)
        expected_rsp_q.push_back(timer_step(opcode_i, port_select_i, write_data_i));
    end
  end
endmodule

// ===== tb/tb_interval_timer_8254.sv =====
// ----------------------------------------------------------------------------
// tb_interval_timer_8254
// Stimulus and verdict for the three-channel interval timer.
// ----------------------------------------------------------------------------
// Drive directed port sequences, then random programming / tick / read
// traffic under several idling phases and one long receiver hold-off. The
// checker beside the block predicts every result and counts mismatches.
module tb_interval_timer_8254;

  localparam int LIMIT = 400000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] opcode;
  logic [2:0] port_sel;
  logic [7:0] wdata;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] rdata;
  logic       tout0;
  logic       fault;
  int         errors;
  int         pending;
  int         cycles = 0;
  int         send_idle_pct;
  int         recv_stall_pct;
  bit         hold_off;
  int         sent;

  interval_timer_8254 #(.CHANNELS(3)) i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .opcode_i(opcode), .port_select_i(port_sel), .write_data_i(wdata),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .read_data_o(rdata), .timer_out0_o(tout0), .fault_o(fault)
  );

  tb_interval_timer_8254_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .opcode_i(opcode), .port_select_i(port_sel), .write_data_i(wdata),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .read_data_i(rdata), .timer_out0_i(tout0), .fault_i(fault),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: end the run at a generous cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: stall at random, or hold off entirely while asked.
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // Offer one transfer and hold it until accepted; idle first at random.
  task automatic send(logic [1:0] op, logic [2:0] port, logic [7:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    port_sel <= port;
    wdata    <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic ctrl(logic [7:0] d);
    send(itp_pkg::OP_WRITE, itp_pkg::PORT_CTRL, d);
  endtask

  // Program a channel with a mode, word access and a count.
  task automatic program_channel(int c, logic [2:0] m, logic [15:0] n);
    ctrl({2'(c), 2'b11, m, 1'b0});
    send(itp_pkg::OP_WRITE, 3'(c), n[7:0]);
    send(itp_pkg::OP_WRITE, 3'(c), n[15:8]);
  endtask

  // Mostly small counts so that terminal counts actually arrive.
  function automatic logic [15:0] pick_count();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'($urandom);
      default: return 16'($urandom_range(1, 12));
    endcase
  endfunction

  task automatic random_item();
    int c;
    c = $urandom_range(2);
    case ($urandom_range(19))
      0, 1:    program_channel(c, 3'($urandom), pick_count());
      2:       ctrl({2'(c), 2'($urandom_range(1, 3)), 3'($urandom), 1'b0});
      3:       ctrl({2'(c), 6'b0});                    // count latch
      4:       ctrl({2'b11, 2'($urandom), 3'($urandom), 1'b0}); // read-back
      5:       send(itp_pkg::OP_WRITE, 3'(c), 8'($urandom));
      6:       send(itp_pkg::OP_WRITE, itp_pkg::PORT_GATE, 8'($urandom));
      7, 8, 9: send(itp_pkg::OP_READ, 3'(c), 8'($urandom));
      10:      send(itp_pkg::OP_READ, 3'($urandom_range(3, 7)), 8'($urandom));
      11:      send(2'($urandom), 3'($urandom), 8'($urandom)); // noise
      default: send(itp_pkg::OP_TICK, 3'($urandom), 8'($urandom));
    endcase
  endtask

  initial begin
    int waits;
    rst_n = 1'b0; in_valid = 1'b0; opcode = itp_pkg::OP_TICK; port_sel = '0; wdata = '0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_off = 1'b0; sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: unset byte order, control read, BCD word, modes 0, 3, 5, 6 and 7.
    send(itp_pkg::OP_READ, 3'd0, 8'h00);
    send(itp_pkg::OP_WRITE, 3'd1, 8'hff);
    send(itp_pkg::OP_READ, itp_pkg::PORT_CTRL, 8'h00);
    ctrl(8'h01);
    ctrl(8'h00);                                  // latch with order unset
    program_channel(0, 3'd0, 16'h0003);
    program_channel(1, 3'd6, 16'h0000);           // 65536
    program_channel(2, 3'd7, 16'h0005);
    send(itp_pkg::OP_WRITE, itp_pkg::PORT_GATE, 8'h01);
    send(itp_pkg::OP_READ, itp_pkg::PORT_GATE, 8'h00);
    repeat (4) send(itp_pkg::OP_TICK, 3'd0, 8'h00);
    ctrl(8'b11_00_111_0);                          // read-back count+status, all
    send(itp_pkg::OP_READ, 3'd0, 8'h00);
    send(itp_pkg::OP_READ, 3'd0, 8'h00);
    send(itp_pkg::OP_READ, 3'd0, 8'h00);
    ctrl(8'h10 | 8'h00 | 8'b01_01_011_0);          // ch1 LSB mode 3
    send(itp_pkg::OP_WRITE, 3'd1, 8'hff);
    send(itp_pkg::OP_READ, 3'd1, 8'h00);
    ctrl(8'b10_10_101_0);                          // ch2 MSB mode 5
    send(itp_pkg::OP_WRITE, 3'd2, 8'h80);
    send(itp_pkg::OP_READ, 3'd2, 8'h00);
    send(itp_pkg::OP_READ, 3'd7, 8'haa);
    send(2'd3, 3'd0, 8'h55);

    // Random phases: none, sender idle, receiver stall, both.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 48 : (ph == 3) ? 9 : 0;
      recv_stall_pct = (ph == 2) ? 48 : (ph == 3) ? 9 : 0;
      if (ph == 2) begin
        // Long hold-off while offers keep coming, to back up the input.
        fork
          begin
            hold_off = 1'b1;
            repeat (60) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      repeat (390) random_item();
    end
    in_valid <= 1'b0;

    waits = 0;
    while (pending != 0 && waits < 10000) begin
      @(posedge clk);
      waits++;
    end
    repeat (5) @(posedge clk);
    $display("covered %0d transfers: all modes, latches, read-back, gate, faults", sent);
    $display("idling phases plus a long receiver hold-off; mismatches %0d", errors);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/itp_pkg.sv
rtl/core/itp_chan.sv
rtl/core/interval_timer_8254.sv
tb/tb_interval_timer_8254_checker.sv
tb/tb_interval_timer_8254.sv
